// File: rtl/core/hsft_pkg.sv
package hsft_pkg;

  localparam int unsigned RAW_W   = 16;
  localparam int unsigned TEMP_W  = 15;
  localparam int unsigned HUMI_W  = 14;
  localparam int unsigned TPROD_W = 31;
  localparam int unsigned HPROD_W = 30;

  localparam logic [7:0] CRC_INIT_C = 8'hFF;
  localparam logic [7:0] CRC_POLY_C = 8'h31;

  // Conversion spans in hundredths and the temperature offset.
  localparam logic [TEMP_W-1:0]        TEMP_SPAN_C = 15'd17500;
  localparam logic [HUMI_W-1:0]        HUMI_SPAN_C = 14'd10000;
  localparam logic signed [TEMP_W:0]   TEMP_OFS_C  = 16'sd4500;

  // Accepted window expressed on the scaled value before the offset is removed.
  localparam logic [TEMP_W-1:0] SCALED_LO_C = 15'd500;
  localparam logic [TEMP_W-1:0] SCALED_HI_C = 15'd17000;

  localparam logic [2:0] LAST_POS_C = 3'd5;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TEMP_CRC = 3'd1,
    ST_HUMI_CRC = 3'd2,
    ST_RANGE    = 3'd3,
    ST_BUS_ERR  = 3'd4
  } hsft_status_e;

  typedef enum logic [1:0] {
    CFG_ON_THR   = 2'd0,
    CFG_OFF_THR  = 2'd1,
    CFG_OVERRIDE = 2'd2,
    CFG_LEVEL    = 2'd3
  } hsft_cfg_idx_e;

  typedef enum logic {
    ACT_BYTE    = 1'b0,
    ACT_BUS_ERR = 1'b1
  } hsft_action_e;

  // One finished frame as handed from the front end to the back end.
  typedef struct packed {
    hsft_status_e       status;
    logic [RAW_W-1:0]   temp_raw;
    logic [RAW_W-1:0]   humi_raw;
  } hsft_rec_t;

  typedef struct packed {
    logic [TEMP_W-1:0] on_thr;
    logic [TEMP_W-1:0] off_thr;
    logic              override_en;
    logic              manual_level;
  } hsft_cfg_t;

  typedef struct packed {
    hsft_status_e      status;
    logic [TEMP_W-1:0] temp;
    logic [HUMI_W-1:0] humi;
    logic              relay;
  } hsft_result_t;

  // CRC-8, MSB first, no final XOR.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY_C) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: rtl/core/humidity_sensor_frame_thermostat.sv
// Decodes the six-byte measurement reply of a temperature and humidity sensor and
// drives a thermostat relay. Each input word carries one reply byte in tdata (order:
// temperature MSB, LSB, CRC, humidity MSB, LSB, CRC) and tuser = 0, or a bus error
// with tuser = 1, which aborts the frame and restarts at the first byte. Both 16-bit
// words are checked with CRC-8 (polynomial 0x31, start 0xFF). One output word
// appears per completed frame or bus error and none for the other bytes; it carries
// the status in tuser and temperature and humidity in hundredths of a unit in tdata,
// with the values forced to zero unless the status is ok. Only a good reading
// moves the relay, either through the on/off hysteresis thresholds or, with the
// override set, to the manual level. The block takes one word every clock cycle
// while the result side keeps up; the front end tracks the CRC and byte position for
// each byte, a two-entry frame queue separates it from the back end, and the back
// end registers the constant multiplications in its product stage and computes the
// scaling by 1/65535, range check and relay update into the output register. A
// frame result passes from the queue through the product stage to the output
// register, which lets the next frame proceed while a result waits for tready. When
// results back up, the output register, the product stage and the queue hold four
// of them, and s_axis_tready drops for every input word until the queue frees an
// entry. The configuration registers take effect on the next frame and should be
// written only while no frame result is pending.
module humidity_sensor_frame_thermostat (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] action

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi,
                                      // [29] relay_on, [31:30] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] status

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);

  hsft_pkg::hsft_cfg_t    cfg_q, cfg_d;
  hsft_pkg::hsft_rec_t    push_rec, pop_rec;
  hsft_pkg::hsft_result_t res;
  logic                   push, pop, queue_full, queue_valid;

  // Configuration register file; indices follow the register list.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hsft_pkg::CFG_ON_THR:   cfg_d.on_thr       = cfg_data_i;
        hsft_pkg::CFG_OFF_THR:  cfg_d.off_thr      = cfg_data_i;
        hsft_pkg::CFG_OVERRIDE: cfg_d.override_en  = cfg_data_i[0];
        hsft_pkg::CFG_LEVEL:    cfg_d.manual_level = cfg_data_i[0];
        default:                cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_thr       <= 15'd2500;
      cfg_q.off_thr      <= 15'd2400;
      cfg_q.override_en  <= 1'b0;
      cfg_q.manual_level <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hsft_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .queue_full_i (queue_full),
    .action_i     (s_axis_tuser),
    .data_byte_i  (s_axis_tdata),
    .byte_ready_o (s_axis_tready),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  hsft_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (queue_full),
    .pop_i      (pop),
    .valid_o    (queue_valid),
    .pop_rec_o  (pop_rec)
  );

  hsft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rec_valid_i (queue_valid),
    .rec_i       (pop_rec),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.relay, res.humi, res.temp};
  assign m_axis_tuser = res.status;

endmodule

// File: rtl/core/hsft_front.sv
module hsft_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic                queue_full_i,
  input  logic                action_i,
  input  logic [7:0]          data_byte_i,
  output logic                byte_ready_o,
  output logic                push_o,
  output hsft_pkg::hsft_rec_t rec_o
);

  logic [2:0]                   pos_q, pos_d, pos_eff;
  logic [7:0]                   crc_q, crc_d, crc_fed;
  logic                         tcrc_ok_q, tcrc_ok_d;
  logic [hsft_pkg::RAW_W-1:0]   traw_q, traw_d, hraw_q, hraw_d;
  logic                         accept;

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && !queue_full_i;

  // Positions past the last byte cannot occur, but restart the frame if they do.
  assign pos_eff = (pos_q > hsft_pkg::LAST_POS_C) ? 3'd0 : pos_q;
  assign crc_fed = hsft_pkg::crc8_feed((pos_eff == 3'd0) ? hsft_pkg::CRC_INIT_C : crc_q,
                                       data_byte_i);

  always_comb begin
    pos_d          = pos_q;
    crc_d          = crc_q;
    tcrc_ok_d      = tcrc_ok_q;
    traw_d         = traw_q;
    hraw_d         = hraw_q;
    push_o         = 1'b0;
    rec_o.status   = hsft_pkg::ST_OK;
    rec_o.temp_raw = traw_q;
    rec_o.humi_raw = hraw_q;
    if (accept) begin
      if (action_i == hsft_pkg::ACT_BUS_ERR) begin
        pos_d        = 3'd0;
        crc_d        = hsft_pkg::CRC_INIT_C;
        push_o       = 1'b1;
        rec_o.status = hsft_pkg::ST_BUS_ERR;
      end else begin
        pos_d = pos_eff + 3'd1;
        unique case (pos_eff)
          3'd0: begin
            crc_d  = crc_fed;
            traw_d = {data_byte_i, 8'h00};
          end
          3'd1: begin
            crc_d  = crc_fed;
            traw_d = {traw_q[15:8], data_byte_i};
          end
          3'd2: begin
            tcrc_ok_d = (crc_q == data_byte_i);
            crc_d     = hsft_pkg::CRC_INIT_C;
          end
          3'd3: begin
            crc_d  = crc_fed;
            hraw_d = {data_byte_i, 8'h00};
          end
          3'd4: begin
            crc_d  = crc_fed;
            hraw_d = {hraw_q[15:8], data_byte_i};
          end
          default: begin
            pos_d  = 3'd0;
            crc_d  = hsft_pkg::CRC_INIT_C;
            push_o = 1'b1;
            if (!tcrc_ok_q) begin
              rec_o.status = hsft_pkg::ST_TEMP_CRC;
            end else if (crc_q != data_byte_i) begin
              rec_o.status = hsft_pkg::ST_HUMI_CRC;
            end else begin
              rec_o.status = hsft_pkg::ST_OK;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 3'd0;
      crc_q     <= hsft_pkg::CRC_INIT_C;
      tcrc_ok_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      tcrc_ok_q <= tcrc_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    traw_q <= traw_d;
    hraw_q <= hraw_d;
  end

endmodule

// File: rtl/core/hsft_queue.sv
module hsft_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hsft_pkg::hsft_rec_t push_rec_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output hsft_pkg::hsft_rec_t pop_rec_o
);

  hsft_pkg::hsft_rec_t entry_q [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          count_q, count_d;
  logic                do_push, do_pop;

  assign full_o    = (count_q == 2'd2);
  assign valid_o   = (count_q != 2'd0);
  assign pop_rec_o = entry_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

// File: rtl/core/hsft_back.sv
module hsft_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hsft_pkg::hsft_cfg_t    cfg_i,
  input  logic                   rec_valid_i,
  input  hsft_pkg::hsft_rec_t    rec_i,
  output logic                   pop_o,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output hsft_pkg::hsft_result_t res_o
);

  // Stage A: products of the raw values and the spans.
  logic                         a_valid_q, a_valid_d;
  hsft_pkg::hsft_status_e       a_status_q;
  logic [hsft_pkg::TPROD_W-1:0] a_tprod_q;
  logic [hsft_pkg::HPROD_W-1:0] a_hprod_q;

  // Output register and thermostat state.
  logic                         out_valid_q, out_valid_d;
  hsft_pkg::hsft_result_t       out_q, out_d;
  logic                         therm_q, therm_d, relay_q, relay_d;

  logic                         out_ready, a_adv;
  logic [31:0]                  tsum, hsum;
  logic [hsft_pkg::TEMP_W-1:0]  scaled_t;
  logic [hsft_pkg::HUMI_W-1:0]  scaled_h;
  logic signed [hsft_pkg::TEMP_W:0] temp_wide;
  logic [hsft_pkg::TEMP_W-1:0]  temp;
  logic                         range_bad, meas_ok, therm_next;

  assign out_ready = !out_valid_q || res_ready_i;
  assign a_adv     = a_valid_q && out_ready;
  assign pop_o     = rec_valid_i && (!a_valid_q || out_ready);

  always_comb begin
    a_valid_d = a_valid_q;
    if (pop_o) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
  end

  // Exact floor(x / 65535) for x below 2^31: (x + (x >> 16) + 1) >> 16.
  assign tsum      = {1'b0, a_tprod_q} + {17'd0, a_tprod_q[30:16]} + 32'd1;
  assign hsum      = {2'b00, a_hprod_q} + {18'd0, a_hprod_q[29:16]} + 32'd1;
  assign scaled_t  = tsum[30:16];
  assign scaled_h  = hsum[29:16];
  assign temp_wide = $signed({1'b0, scaled_t}) - hsft_pkg::TEMP_OFS_C;
  assign temp      = temp_wide[hsft_pkg::TEMP_W-1:0];
  assign range_bad = (scaled_t < hsft_pkg::SCALED_LO_C) || (scaled_t > hsft_pkg::SCALED_HI_C);
  assign meas_ok   = (a_status_q == hsft_pkg::ST_OK) && !range_bad;

  always_comb begin
    if ($signed(temp) >= $signed(cfg_i.on_thr)) begin
      therm_next = 1'b1;
    end else if ($signed(temp) <= $signed(cfg_i.off_thr)) begin
      therm_next = 1'b0;
    end else begin
      therm_next = therm_q;
    end
  end

  always_comb begin
    therm_d     = therm_q;
    relay_d     = relay_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (a_adv) begin
      if (meas_ok) begin
        if (cfg_i.override_en) begin
          relay_d = cfg_i.manual_level;
        end else begin
          therm_d = therm_next;
          relay_d = therm_next;
        end
      end
      out_valid_d  = 1'b1;
      out_d.status = ((a_status_q == hsft_pkg::ST_OK) && range_bad) ? hsft_pkg::ST_RANGE
                                                                     : a_status_q;
      out_d.temp   = meas_ok ? temp : '0;
      out_d.humi   = meas_ok ? scaled_h : '0;
      out_d.relay  = relay_d;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      therm_q     <= 1'b0;
      relay_q     <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      therm_q     <= therm_d;
      relay_q     <= relay_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_status_q <= rec_i.status;
      a_tprod_q  <= {15'd0, rec_i.temp_raw} * {16'd0, hsft_pkg::TEMP_SPAN_C};
      a_hprod_q  <= {14'd0, rec_i.humi_raw} * {16'd0, hsft_pkg::HUMI_SPAN_C};
    end
    out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// File: rtl/core/hsft_checker.sv
module hsft_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Every failed frame reports zero readings.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != hsft_pkg::ST_OK) |-> (m_axis_tdata[28:0] == 29'd0))
    else $error("failed frame carries nonzero readings");

  // A good reading lies inside the accepted window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == hsft_pkg::ST_OK) |->
      ($signed(m_axis_tdata[14:0]) >= -15'sd4000) &&
      ($signed(m_axis_tdata[14:0]) <= 15'sd12500) &&
      (m_axis_tdata[28:15] <= 14'd10000))
    else $error("good reading outside its range");

endmodule

bind humidity_sensor_frame_thermostat hsft_checker u_hsft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: test/tb.sv
module tb;

  // Accepted temperature window after the offset is removed, in hundredths.
  localparam int TEMP_FLOOR_CENTI = -4000;
  localparam int TEMP_CEIL_CENTI  = 12500;
  localparam int FULL_SCALE_RAW   = 65535;
  // Cycles to let pass after the last result before the block counts as idle.
  localparam int SETTLE_CYCLES    = 8;
  // Length of the long receiver stall that fills the frame queue.
  localparam int RX_HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int PHASES           = 7;
  localparam int WORDS_PER_PHASE  = 170;

  // Predicts the decoder and thermostat from the accepted input words and holds
  // the readings that the block still owes.
  class thermostat_scoreboard;
    logic signed [hsft_pkg::TEMP_W-1:0] on_thr;
    logic signed [hsft_pkg::TEMP_W-1:0] off_thr;
    logic                               override_en;
    logic                               manual_lvl;
    logic [2:0]                         byte_pos;
    logic [7:0]                         crc;
    logic [hsft_pkg::RAW_W-1:0]         temp_raw;
    logic [hsft_pkg::RAW_W-1:0]         humi_raw;
    logic                               temp_crc_good;
    logic                               thermo_on;
    logic                               relay;
    hsft_pkg::hsft_result_t             readings_q[$];
    int unsigned                        failures;

    function new();
      on_thr        = 15'sd2500;
      off_thr       = 15'sd2400;
      override_en   = 1'b0;
      manual_lvl    = 1'b0;
      byte_pos      = 3'd0;
      crc           = hsft_pkg::CRC_INIT_C;
      temp_raw      = '0;
      humi_raw      = '0;
      temp_crc_good = 1'b0;
      thermo_on     = 1'b0;
      relay         = 1'b0;
      failures      = 0;
    endfunction

    // CRC-8 over one byte, most significant bit first.
    static function logic [7:0] crc_feed(logic [7:0] c_in, logic [7:0] b);
      logic [7:0] c;
      c = c_in ^ b;
      for (int i = 0; i < 8; i++) begin
        if (c[7]) begin
          c = {c[6:0], 1'b0} ^ hsft_pkg::CRC_POLY_C;
        end else begin
          c = {c[6:0], 1'b0};
        end
      end
      return c;
    endfunction

    function void set_register(hsft_pkg::hsft_cfg_idx_e idx,
                               logic [hsft_pkg::TEMP_W-1:0] v);
      case (idx)
        hsft_pkg::CFG_ON_THR:   on_thr      = v;
        hsft_pkg::CFG_OFF_THR:  off_thr     = v;
        hsft_pkg::CFG_OVERRIDE: override_en = v[0];
        hsft_pkg::CFG_LEVEL:    manual_lvl  = v[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return readings_q.size();
    endfunction

    // The relay level of a reading is whatever it is after the frame is handled.
    function void queue_reading(hsft_pkg::hsft_status_e st, int t_centi,
                                int unsigned h_centi);
      hsft_pkg::hsft_result_t r;
      r.status = st;
      r.temp   = t_centi[hsft_pkg::TEMP_W-1:0];
      r.humi   = h_centi[hsft_pkg::HUMI_W-1:0];
      r.relay  = relay;
      readings_q.push_back(r);
    endfunction

    function void note_byte(hsft_pkg::hsft_action_e act, logic [7:0] b);
      logic [2:0]  p;
      logic        humi_good;
      int unsigned scaled_t;
      int unsigned scaled_h;
      int          t_centi;
      if (act == hsft_pkg::ACT_BUS_ERR) begin
        byte_pos = 3'd0;
        crc      = hsft_pkg::CRC_INIT_C;
        queue_reading(hsft_pkg::ST_BUS_ERR, 0, 0);
        return;
      end
      p = (byte_pos > hsft_pkg::LAST_POS_C) ? 3'd0 : byte_pos;
      case (p)
        3'd0: begin
          crc      = crc_feed(hsft_pkg::CRC_INIT_C, b);
          temp_raw = {b, 8'h00};
        end
        3'd1: begin
          crc           = crc_feed(crc, b);
          temp_raw[7:0] = b;
        end
        3'd2: begin
          temp_crc_good = (crc == b);
          crc           = hsft_pkg::CRC_INIT_C;
        end
        3'd3: begin
          crc      = crc_feed(crc, b);
          humi_raw = {b, 8'h00};
        end
        3'd4: begin
          crc           = crc_feed(crc, b);
          humi_raw[7:0] = b;
        end
        default: ;
      endcase
      if (p != hsft_pkg::LAST_POS_C) begin
        byte_pos = p + 3'd1;
        return;
      end
      // Sixth byte: the humidity CRC closes the frame.
      byte_pos  = 3'd0;
      humi_good = (crc == b);
      crc       = hsft_pkg::CRC_INIT_C;
      if (!temp_crc_good) begin
        queue_reading(hsft_pkg::ST_TEMP_CRC, 0, 0);
      end else if (!humi_good) begin
        queue_reading(hsft_pkg::ST_HUMI_CRC, 0, 0);
      end else begin
        scaled_t = (32'(hsft_pkg::TEMP_SPAN_C) * 32'(temp_raw)) / FULL_SCALE_RAW;
        scaled_h = (32'(hsft_pkg::HUMI_SPAN_C) * 32'(humi_raw)) / FULL_SCALE_RAW;
        t_centi  = int'(scaled_t) - int'(hsft_pkg::TEMP_OFS_C);
        if (t_centi < TEMP_FLOOR_CENTI || t_centi > TEMP_CEIL_CENTI) begin
          queue_reading(hsft_pkg::ST_RANGE, 0, 0);
        end else begin
          if (override_en) begin
            relay = manual_lvl;
          end else begin
            // With crossed thresholds the on test still comes first.
            if (t_centi >= int'(on_thr)) begin
              thermo_on = 1'b1;
            end else if (t_centi <= int'(off_thr)) begin
              thermo_on = 1'b0;
            end
            relay = thermo_on;
          end
          queue_reading(hsft_pkg::ST_OK, t_centi, scaled_h);
        end
      end
    endfunction

    function void mismatch(string msg);
      if (failures < 10) begin
        $display("MISMATCH: %s", msg);
      end
      failures++;
    endfunction

    function void check_reading(logic [2:0] st, logic [31:0] d);
      hsft_pkg::hsft_result_t want;
      if (readings_q.size() == 0) begin
        mismatch($sformatf("reading with none pending: status %0d tdata %h", st, d));
        return;
      end
      want = readings_q.pop_front();
      if (st !== want.status) begin
        mismatch($sformatf("status expected %0d got %0d", want.status, st));
      end
      if (d[14:0] !== want.temp) begin
        mismatch($sformatf("temperature expected %0d got %0d",
                           $signed(want.temp), $signed(d[14:0])));
      end
      if (d[28:15] !== want.humi) begin
        mismatch($sformatf("humidity expected %0d got %0d", want.humi, d[28:15]));
      end
      if (d[29] !== want.relay) begin
        mismatch($sformatf("relay expected %0b got %0b", want.relay, d[29]));
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = 2'd0;
  logic [14:0] cfg_data_i    = 15'd0;

  thermostat_scoreboard sb = new();

  // Idle rates in percent, set per phase by the stimulus process.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // The stimulus raises a long receiver stall by bumping the request count.
  int hold_requests = 0;
  int hold_served   = 0;
  int rx_hold_left  = 0;
  int words_sent    = 0;
  int cycle_count   = 0;

  humidity_sensor_frame_thermostat dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A run that never finishes counts as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: stalls at random, or for a long stretch on request, so that the
  // frame queue inside the block fills and the input side backs up.
  always @(negedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served  = hold_requests;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every output word that is taken is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_reading(m_axis_tuser, m_axis_tdata);
    end
  end

  // Offers one word, after a random idle stretch, and waits until it is taken.
  // Inputs only move at the falling edge, so tvalid stays high from one word to
  // the next when no idle cycle falls between them.
  task automatic send_word(input hsft_pkg::hsft_action_e act, input logic [7:0] b);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(act, b);
    words_sent++;
  endtask

  // A full six-byte reply; either CRC can be spoiled by a random nonzero flip.
  task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                            input bit spoil_t, input bit spoil_h);
    logic [7:0] t_crc;
    logic [7:0] h_crc;
    t_crc = thermostat_scoreboard::crc_feed(
              thermostat_scoreboard::crc_feed(hsft_pkg::CRC_INIT_C, t_raw[15:8]),
              t_raw[7:0]);
    h_crc = thermostat_scoreboard::crc_feed(
              thermostat_scoreboard::crc_feed(hsft_pkg::CRC_INIT_C, h_raw[15:8]),
              h_raw[7:0]);
    if (spoil_t) t_crc ^= 8'($urandom_range(1, 255));
    if (spoil_h) h_crc ^= 8'($urandom_range(1, 255));
    send_word(hsft_pkg::ACT_BYTE, t_raw[15:8]);
    send_word(hsft_pkg::ACT_BYTE, t_raw[7:0]);
    send_word(hsft_pkg::ACT_BYTE, t_crc);
    send_word(hsft_pkg::ACT_BYTE, h_raw[15:8]);
    send_word(hsft_pkg::ACT_BYTE, h_raw[7:0]);
    send_word(hsft_pkg::ACT_BYTE, h_crc);
  endtask

  task automatic write_reg(input hsft_pkg::hsft_cfg_idx_e idx, input logic [14:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    sb.set_register(idx, v);
  endtask

  // Writes all four registers back to back. The one-bit registers get random
  // upper bits, which the block must ignore.
  task automatic program_thermostat(input int on_c, input int off_c,
                                    input bit ovr, input bit lvl);
    write_reg(hsft_pkg::CFG_ON_THR,   15'(on_c));
    write_reg(hsft_pkg::CFG_OFF_THR,  15'(off_c));
    write_reg(hsft_pkg::CFG_OVERRIDE, {14'($urandom()), ovr});
    write_reg(hsft_pkg::CFG_LEVEL,    {14'($urandom()), lvl});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Brings the block to idle: close any open frame with a bus error, stop
  // offering words, wait for every owed reading and then for the pipeline.
  task automatic settle();
    if (sb.byte_pos != 3'd0) begin
      send_word(hsft_pkg::ACT_BUS_ERR, 8'($urandom()));
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed frames with random content and an occasional bad CRC;
  // the rest are aborted frames and loose noise words. Part of the temperatures
  // land close to a threshold so the relay keeps switching.
  task automatic random_traffic(input int words);
    int          first;
    int          pick;
    int          n;
    int          target;
    int          r;
    logic [15:0] t_raw;
    first = words_sent;
    while (words_sent - first < words) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        if ($urandom_range(99) < 60) begin
          t_raw = 16'($urandom());
        end else begin
          target = ($urandom_range(1) != 0) ? int'(sb.on_thr) : int'(sb.off_thr);
          r = (target + int'(hsft_pkg::TEMP_OFS_C)) * FULL_SCALE_RAW
              / int'(hsft_pkg::TEMP_SPAN_C) + int'($urandom_range(0, 10)) - 5;
          if (r < 0) r = 0;
          if (r > FULL_SCALE_RAW) r = FULL_SCALE_RAW;
          t_raw = 16'(r);
        end
        send_frame(t_raw, 16'($urandom()),
                   $urandom_range(99) < 8, $urandom_range(99) < 8);
      end else if (pick < 90) begin
        n = $urandom_range(0, 5);
        repeat (n) send_word(hsft_pkg::ACT_BYTE, 8'($urandom()));
        send_word(hsft_pkg::ACT_BUS_ERR, 8'($urandom()));
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_word(hsft_pkg::hsft_action_e'($urandom_range(99) < 15),
                             8'($urandom()));
      end
    end
  endtask

  // Register settings per phase: defaults, both thresholds at the low and at the
  // high extreme, crossed thresholds, override to each level, then a wide band.
  int  phase_on[PHASES]  = '{2500, -4500, 13000, 1000, 0, 0, 6000};
  int  phase_off[PHASES] = '{2400, -4500, 13000, 3000, 0, 0, -1000};
  bit  phase_ovr[PHASES] = '{0, 0, 0, 0, 1, 1, 0};
  bit  phase_lvl[PHASES] = '{0, 0, 0, 0, 1, 0, 1};

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 45;
    program_thermostat(2500, 2400, 1'b0, 1'b0);

    // Lowest temperature still accepted, with full-scale humidity.
    send_frame(16'd1873, 16'hFFFF, 1'b0, 1'b0);
    // One step lower falls out of range.
    send_frame(16'd1872, 16'h0000, 1'b0, 1'b0);
    // Highest temperature still accepted; the relay switches on.
    send_frame(16'd63666, 16'h0000, 1'b0, 1'b0);
    // Out of range but with a bad humidity CRC: the CRC status wins.
    send_frame(16'hFFFF, 16'h8000, 1'b0, 1'b1);
    // Both CRCs bad: the temperature CRC wins.
    send_frame(16'h0000, 16'h1234, 1'b1, 1'b1);
    // Bus error in the middle of a frame.
    send_word(hsft_pkg::ACT_BYTE, 8'h66);
    send_word(hsft_pkg::ACT_BYTE, 8'h00);
    send_word(hsft_pkg::ACT_BUS_ERR, 8'hFF);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 12;
        recv_idle_pct = 45;
      end else if (ph < 5) begin
        send_idle_pct = 45;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_thermostat(phase_on[ph], phase_off[ph], phase_ovr[ph], phase_lvl[ph]);
      if (ph == 2) begin
        hold_requests++;
      end
      random_traffic(WORDS_PER_PHASE);
      settle();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
